@@ rtl/lbs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the skinning block.
// No dependencies; imported by lbs_lane, lbs_merge, the top module and the testbench.
package lbs_pkg;

    localparam int COORD_W    = 24;  // signed Q8.16
    localparam int COORD_FRAC = 16;
    localparam int WEIGHT_W   = 16;  // unsigned Q1.15
    localparam int WEIGHT_FRAC = 15;
    localparam int ID_W       = 6;
    localparam int ELEM_W     = 4;
    localparam int INFL       = 4;
    localparam int ELEMS      = 12;
    localparam int PROD_W     = 2 * COORD_W;          // matrix x vector product
    localparam int ROW_W      = PROD_W + 2;           // three products plus translation
    localparam int WPROD_W    = COORD_W + WEIGHT_W + 1; // row result x weight
    localparam int ACC_W      = WPROD_W + 2;          // sum of four influences
    localparam int SAT_W      = 36;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_SKIN = 1'b1
    } op_t;

    typedef struct packed
    {
        logic                       operation;
        logic [ID_W-1:0]            bone_slot;
        logic [ELEM_W-1:0]          element_index;
        logic signed [COORD_W-1:0]  element_value;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  pos_z;
        logic signed [COORD_W-1:0]  nrm_x;
        logic signed [COORD_W-1:0]  nrm_y;
        logic signed [COORD_W-1:0]  nrm_z;
        logic [INFL*ID_W-1:0]       bone_ids;
        logic [INFL*WEIGHT_W-1:0]   bone_weights;
    } in_beat_t;

    typedef struct packed
    {
        logic signed [COORD_W-1:0]  out_pos_x;
        logic signed [COORD_W-1:0]  out_pos_y;
        logic signed [COORD_W-1:0]  out_pos_z;
        logic signed [COORD_W-1:0]  out_nrm_x;
        logic signed [COORD_W-1:0]  out_nrm_y;
        logic signed [COORD_W-1:0]  out_nrm_z;
    } out_beat_t;

    // Palette write request broadcast to every lane
    typedef struct packed
    {
        logic                       en;
        logic [ID_W-1:0]            slot;
        logic [ELEM_W-1:0]          elem;
        logic signed [COORD_W-1:0]  value;
    } pal_wr_t;

    // Clamp a wide signed value to the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
        lo = -hi - SAT_W'(1);
        if (v > hi)
            sat_coord = hi[COORD_W-1:0];
        else if (v < lo)
            sat_coord = lo[COORD_W-1:0];
        else
            sat_coord = v[COORD_W-1:0];
    endfunction

endpackage

@@ rtl/lbs_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read and read enable.
// No dependencies.
module lbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lbs_lane.sv @@
`timescale 1ns / 1ps
// One influence lane: its copy of the bone palette, matrix transform of
// position and normal, rounding, saturation and weighting. Uses lbs_pkg, lbs_ram.
module lbs_lane
    import lbs_pkg::*;
#(
    parameter int BONES = 64
) (
    input  logic                        clk,
    input  logic                        adv,
    input  pal_wr_t                     wr,
    input  logic [ID_W-1:0]             bone_id,
    input  logic [WEIGHT_W-1:0]         weight,
    input  logic signed [COORD_W-1:0]   vec [2][3],
    output logic signed [WPROD_W-1:0]   wprod [6]
);

    localparam int AW = (BONES > 1) ? $clog2(BONES) : 1;

    logic [AW+ID_W-1:0]         waddr_ext;
    logic [AW+ID_W-1:0]         raddr_ext;
    logic [COORD_W-1:0]         mat [ELEMS];
    logic                       hit;

    logic [WEIGHT_W-1:0]        w1_reg, w2_reg, w3_reg;
    logic signed [PROD_W-1:0]   prod_reg [2][3][3];
    logic signed [COORD_W-1:0]  trans_reg [3];
    logic signed [COORD_W-1:0]  xf_next [6];
    logic signed [COORD_W-1:0]  xf_reg [6];
    logic signed [WPROD_W-1:0]  wprod_reg [6];

    assign waddr_ext = {AW'(0), wr.slot};
    assign raddr_ext = {AW'(0), bone_id};
    assign hit = ({1'b0, raddr_ext} < (AW+ID_W+1)'(BONES));

    // Palette copy, one RAM per matrix element
    for (genvar e = 0; e < ELEMS; e++)
    begin : g_elem
        lbs_ram #(
            .WIDTH (COORD_W),
            .DEPTH (BONES)
        ) u_ram (
            .clk   (clk),
            .we    (wr.en && (wr.elem == ELEM_W'(e))),
            .waddr (waddr_ext[AW-1:0]),
            .wdata (wr.value),
            .re    (adv),
            .raddr (raddr_ext[AW-1:0]),
            .rdata (mat[e])
        );
    end

    // Weight follows the read; out-of-range bones weigh zero
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_reg <= hit ? weight : '0;
            w2_reg <= w1_reg;
            w3_reg <= w2_reg;
        end
    end

    // Matrix products: path 0 is position, path 1 is normal
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int p = 0; p < 2; p++)
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        prod_reg[p][r][c] <= $signed(mat[r*4+c]) * vec[p][c];
            for (int r = 0; r < 3; r++)
                trans_reg[r] <= $signed(mat[r*4+3]);
        end
    end

    // Row sums, round half up to Q8.16, saturate
    always_comb
    begin
        logic signed [ROW_W-1:0] s;
        for (int p = 0; p < 2; p++)
            for (int r = 0; r < 3; r++)
            begin
                s = ROW_W'(prod_reg[p][r][0]) + ROW_W'(prod_reg[p][r][1])
                  + ROW_W'(prod_reg[p][r][2]);
                if (p == 0)
                    s = s + (ROW_W'(trans_reg[r]) <<< COORD_FRAC);
                s = s + ROW_W'(1 <<< (COORD_FRAC - 1));
                xf_next[p*3+r] = sat_coord(SAT_W'(s >>> COORD_FRAC));
            end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            xf_reg <= xf_next;
    end

    // Weighting
    always_ff @(posedge clk)
    begin
        if (adv)
            for (int i = 0; i < 6; i++)
                wprod_reg[i] <= xf_reg[i] * $signed({1'b0, w3_reg});
    end

    assign wprod = wprod_reg;

endmodule

@@ rtl/lbs_merge.sv @@
`timescale 1ns / 1ps
// Merge stage: sums the four weighted lane results, rounds and saturates
// into the output data register. Uses lbs_pkg.
module lbs_merge
    import lbs_pkg::*;
(
    input  logic                        clk,
    input  logic                        adv,
    input  logic signed [WPROD_W-1:0]   wprod [INFL][6],
    output out_beat_t                   res
);

    logic signed [COORD_W-1:0] comp_next [6];
    out_beat_t                 res_reg;

    // Sum of influences, round half up to Q8.16, saturate
    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        for (int i = 0; i < 6; i++)
        begin
            acc = ACC_W'(1 <<< (WEIGHT_FRAC - 1));
            for (int k = 0; k < INFL; k++)
                acc = acc + ACC_W'(wprod[k][i]);
            comp_next[i] = sat_coord(SAT_W'(acc >>> WEIGHT_FRAC));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.out_pos_x <= comp_next[0];
            res_reg.out_pos_y <= comp_next[1];
            res_reg.out_pos_z <= comp_next[2];
            res_reg.out_nrm_x <= comp_next[3];
            res_reg.out_nrm_y <= comp_next[4];
            res_reg.out_nrm_z <= comp_next[5];
        end
    end

    assign res = res_reg;

endmodule

@@ rtl/linear_blend_vertex_skinning.sv @@
`timescale 1ns / 1ps
// Linear blend vertex skinning, four influences per vertex.
// Uses lbs_pkg, lbs_lane, lbs_merge (and lbs_ram through the lanes).
//
// Input channel item_valid/item_ready/item carries either a palette load
// (operation = load: one Q8.16 element of one 3x4 bone matrix) or a skin
// beat (position, normal, four bone ids, four Q1.15 weights). Loads give no
// result. Each skin beat gives one result beat on result_valid/
// result_ready/result: skinned position and normal, Q8.16, saturated.
// Four lanes, each with its own palette copy (twelve RAMs of BONES words),
// transform one influence each; a merge stage sums them.
// A skin beat passes the read, multiply, row sum, weight and output registers before result_valid rises.
// Throughput: one beat per cycle; the pipeline stalls as a whole only while
// the output register is full and result_ready is low.
// Reset clears only the valid flags; palette contents are undefined until
// loaded. A load is visible to a skin beat accepted in the next cycle.
module linear_blend_vertex_skinning
    import lbs_pkg::*;
#(
    parameter int BONES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  in_beat_t   item,
    output logic       result_valid,
    input  logic       result_ready,
    output out_beat_t  result
);

    logic                       adv;
    logic                       accept;
    pal_wr_t                    wr;
    logic [4:0]                 vld_reg, vld_next;
    logic signed [COORD_W-1:0]  vec_reg [2][3];
    logic signed [WPROD_W-1:0]  wprod [INFL][6];

    assign adv        = !vld_reg[4] || result_ready;
    assign item_ready = adv;
    assign accept     = item_valid && item_ready;

    // Palette load decode
    always_comb
    begin
        wr.en    = accept && (item.operation == OP_LOAD)
                   && ({9'b0, item.bone_slot} < (ID_W+9)'(BONES))
                   && (item.element_index < ELEM_W'(ELEMS));
        wr.slot  = item.bone_slot;
        wr.elem  = item.element_index;
        wr.value = item.element_value;
    end

    // Vertex held alongside the palette read
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg[0][0] <= item.pos_x;
            vec_reg[0][1] <= item.pos_y;
            vec_reg[0][2] <= item.pos_z;
            vec_reg[1][0] <= item.nrm_x;
            vec_reg[1][1] <= item.nrm_y;
            vec_reg[1][2] <= item.nrm_z;
        end
    end

    // Valid flags: read, multiply, row sum, weight, output
    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
            vld_next = {vld_reg[3:0], accept && (item.operation == OP_SKIN)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    for (genvar k = 0; k < INFL; k++)
    begin : g_lane
        lbs_lane #(
            .BONES (BONES)
        ) u_lane (
            .clk     (clk),
            .adv     (adv),
            .wr      (wr),
            .bone_id (item.bone_ids[k*ID_W +: ID_W]),
            .weight  (item.bone_weights[k*WEIGHT_W +: WEIGHT_W]),
            .vec     (vec_reg),
            .wprod   (wprod[k])
        );
    end

    lbs_merge u_merge (
        .clk   (clk),
        .adv   (adv),
        .wprod (wprod),
        .res   (result)
    );

    assign result_valid = vld_reg[4];

    // A load beat never starts a result
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.operation == OP_LOAD) |=> !vld_reg[0])
        else $error("load beat entered the skin pipeline");

    // A skin beat always enters the pipeline
    a_skin_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.operation == OP_SKIN) |=> vld_reg[0])
        else $error("skin beat lost at entry");

    // While stalled the in-flight beats stay put
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule

@@ tb/linear_blend_vertex_skinning_tb.sv @@
`timescale 1ns / 1ps
// Testbench for linear_blend_vertex_skinning: palette loads and skin beats,
// scored against an in-bench predictor. Depends on lbs_pkg and the RTL top.
module linear_blend_vertex_skinning_tb;
    import lbs_pkg::*;

    localparam int BONES = 64;
    localparam int LATENCY = 4;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_beat_t  item;
    logic      result_valid;
    logic      result_ready;
    out_beat_t result;

    linear_blend_vertex_skinning #(.BONES(BONES)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Predictor state: palette copy
    logic signed [COORD_W-1:0] palette [BONES*ELEMS];
    out_beat_t                 skinned_q [$];
    int                        errors;
    int                        send_idle_pct;
    int                        stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Arithmetic right shift by s with floor semantics
    function automatic longint floor_shr(input longint x, input int s);
        return x >>> s;
    endfunction

    function automatic longint clamp_coord(input longint x);
        longint hi;
        hi = (64'sd1 <<< (COORD_W - 1)) - 1;
        if (x > hi)
            return hi;
        if (x < -hi - 1)
            return -hi - 1;
        return x;
    endfunction

    // One matrix row applied to v; point adds the translation
    function automatic longint bone_row(input int bone, input int row,
                                        input longint v0, input longint v1,
                                        input longint v2, input bit point);
        longint  hi;
        longint  lo;
        longint  p;
        longint  v [3];
        int      base;
        v[0] = v0; v[1] = v1; v[2] = v2;
        hi = 0;
        lo = 0;
        base = bone * ELEMS + row * 4;
        for (int c = 0; c < 3; c++)
        begin
            p = longint'(palette[base + c]) * v[c];
            hi += floor_shr(p, COORD_FRAC);
            lo += p & ((64'sd1 <<< COORD_FRAC) - 1);
        end
        if (point)
            hi += longint'(palette[base + 3]);
        lo += 64'sd1 <<< (COORD_FRAC - 1);
        hi += lo >>> COORD_FRAC;
        return clamp_coord(hi);
    endfunction

    // Apply one beat to the predictor; skin beats push an expectation
    function automatic void predict_beat(input in_beat_t b);
        longint    acc [6];
        longint    w;
        longint    v;
        int        id;
        out_beat_t e;
        if (op_t'(b.operation) == OP_LOAD)
        begin
            if (b.bone_slot < BONES && b.element_index < ELEMS)
                palette[b.bone_slot * ELEMS + b.element_index] = b.element_value;
            return;
        end
        for (int r = 0; r < 6; r++)
            acc[r] = 0;
        for (int k = 0; k < INFL; k++)
        begin
            id = b.bone_ids[k*ID_W +: ID_W];
            w  = longint'(b.bone_weights[k*WEIGHT_W +: WEIGHT_W]);
            if (id >= BONES)
                continue;
            for (int r = 0; r < 3; r++)
            begin
                acc[r] += bone_row(id, r, b.pos_x, b.pos_y, b.pos_z, 1'b1) * w;
                acc[3+r] += bone_row(id, r, b.nrm_x, b.nrm_y, b.nrm_z, 1'b0) * w;
            end
        end
        for (int r = 0; r < 6; r++)
        begin
            v = clamp_coord(floor_shr(acc[r] + (64'sd1 <<< (WEIGHT_FRAC - 1)),
                                      WEIGHT_FRAC));
            acc[r] = v;
        end
        e.out_pos_x = acc[0][COORD_W-1:0];
        e.out_pos_y = acc[1][COORD_W-1:0];
        e.out_pos_z = acc[2][COORD_W-1:0];
        e.out_nrm_x = acc[3][COORD_W-1:0];
        e.out_nrm_y = acc[4][COORD_W-1:0];
        e.out_nrm_z = acc[5][COORD_W-1:0];
        skinned_q.push_back(e);
    endfunction

    // Drive one beat and hold it until accepted; valid drops only while idling
    task automatic send_beat(input in_beat_t b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= b;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_beat(b);
        @(negedge clk);
    endtask

    // Receiver stall pattern
    always @(negedge clk)
        result_ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);

    // Result scoreboard
    always @(posedge clk)
    begin
        out_beat_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (skinned_q.size() == 0)
            begin
                $error("unexpected result beat %h", result);
                errors++;
            end
            else
            begin
                e = skinned_q.pop_front();
                if (result.out_pos_x !== e.out_pos_x)
                begin
                    $error("out_pos_x exp %h got %h", e.out_pos_x, result.out_pos_x);
                    errors++;
                end
                if (result.out_pos_y !== e.out_pos_y)
                begin
                    $error("out_pos_y exp %h got %h", e.out_pos_y, result.out_pos_y);
                    errors++;
                end
                if (result.out_pos_z !== e.out_pos_z)
                begin
                    $error("out_pos_z exp %h got %h", e.out_pos_z, result.out_pos_z);
                    errors++;
                end
                if (result.out_nrm_x !== e.out_nrm_x)
                begin
                    $error("out_nrm_x exp %h got %h", e.out_nrm_x, result.out_nrm_x);
                    errors++;
                end
                if (result.out_nrm_y !== e.out_nrm_y)
                begin
                    $error("out_nrm_y exp %h got %h", e.out_nrm_y, result.out_nrm_y);
                    errors++;
                end
                if (result.out_nrm_z !== e.out_nrm_z)
                begin
                    $error("out_nrm_z exp %h got %h", e.out_nrm_z, result.out_nrm_z);
                    errors++;
                end
            end
        end
    end

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return COORD_W'($urandom_range(131071)) - 24'd65536;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic in_beat_t load_beat(input int slot, input int elem,
                                           input logic [COORD_W-1:0] value);
        in_beat_t b;
        b = in_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom});
        b.operation     = OP_LOAD;
        b.bone_slot     = ID_W'(slot);
        b.element_index = ELEM_W'(elem);
        b.element_value = value;
        return b;
    endfunction

    // Skin beat using only written bones, except ids out of range
    function automatic in_beat_t skin_beat(input int nbones);
        in_beat_t b;
        int       id;
        b = in_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom});
        b.operation = OP_SKIN;
        b.pos_x = rand_coord(); b.pos_y = rand_coord(); b.pos_z = rand_coord();
        b.nrm_x = rand_coord(); b.nrm_y = rand_coord(); b.nrm_z = rand_coord();
        for (int k = 0; k < INFL; k++)
        begin
            id = (nbones < BONES && $urandom_range(7) == 0) ?
                 $urandom_range(63, BONES) : $urandom_range(nbones - 1);
            if (nbones >= BONES && $urandom_range(7) == 0)
                id = $urandom_range(BONES - 1);
            b.bone_ids[k*ID_W +: ID_W] = ID_W'(id);
            case ($urandom_range(3))
                0: b.bone_weights[k*WEIGHT_W +: WEIGHT_W] =
                       WEIGHT_W'($urandom_range(16'h8000));
                1: b.bone_weights[k*WEIGHT_W +: WEIGHT_W] = 16'hFFFF;
                2: b.bone_weights[k*WEIGHT_W +: WEIGHT_W] = 16'h0;
                default: b.bone_weights[k*WEIGHT_W +: WEIGHT_W] = WEIGHT_W'($urandom);
            endcase
        end
        return b;
    endfunction

    // Sender goes quiet until every expected result has been seen
    task automatic drain();
        item_valid <= 1'b0;
        while (skinned_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
        @(negedge clk);
    endtask

    // Identity-like bones, full-scale values, ignored loads
    task automatic test_directed();
        in_beat_t b;
        for (int e = 0; e < ELEMS; e++)
            send_beat(load_beat(0, e, (e % 5 == 0) ? 24'h010000 : 24'h0));
        for (int e = 0; e < ELEMS; e++)
            send_beat(load_beat(1, e, (e % 2) ? 24'h7FFFFF : 24'h800000));
        send_beat(load_beat(0, 12, 24'h123456));
        send_beat(load_beat(1, 15, 24'h7FFFFF));
        b = skin_beat(1);
        b.bone_ids = {6'd0, 6'd0, 6'd0, 6'd0};
        b.bone_weights = {4{16'h8000}};
        send_beat(b);
        b = skin_beat(2);
        b.bone_ids = {6'd1, 6'd0, 6'd1, 6'd1};
        b.bone_weights = {4{16'hFFFF}};
        b.pos_x = 24'h7FFFFF; b.pos_y = 24'h800000; b.pos_z = 24'h7FFFFF;
        send_beat(b);
        b.pos_x = 24'h800000; b.pos_y = 24'h800000; b.pos_z = 24'h800000;
        b.bone_weights = 64'h0;
        send_beat(b);
        drain();
    endtask

    // Mostly skin beats over all bones, with some reloads
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                send_beat(load_beat($urandom_range(BONES - 1),
                                    $urandom_range(15), rand_coord()));
            else
                send_beat(skin_beat(BONES));
        end
    endtask

    task automatic fill_palette();
        for (int s = 0; s < BONES; s++)
            for (int e = 0; e < ELEMS; e++)
                send_beat(load_beat(s, e, (e % 5 == 0 && $urandom_range(1)) ?
                                    24'h010000 : rand_coord()));
    endtask

    initial
    begin
        errors        = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        item_valid    = 1'b0;
        item          = '0;
        result_ready  = 1'b0;
        rst_n         = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        fill_palette();
        test_random(250);
        send_idle_pct = 51;
        test_random(150);
        drain();
        send_idle_pct = 0;
        stall_pct     = 51;
        test_random(150);
        send_idle_pct = 6;
        stall_pct     = 6;
        test_random(150);
        send_idle_pct = 0;
        stall_pct     = 0;
        test_random(150);
        drain();

        if (errors == 0 && skinned_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ linear_blend_vertex_skinning.f @@
rtl/lbs_pkg.sv
rtl/lbs_ram.sv
rtl/lbs_lane.sv
rtl/lbs_merge.sv
rtl/linear_blend_vertex_skinning.sv
tb/linear_blend_vertex_skinning_tb.sv
